FILE: src/frame_dirty_region_tracker_assert.svh
// Assertion macros shared by the tracker checker.
`ifndef FRAME_DIRTY_REGION_TRACKER_ASSERT_SVH
`define FRAME_DIRTY_REGION_TRACKER_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define FDRT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tracker check failed");
// Next-cycle implication, disabled during reset.
`define FDRT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tracker check failed");
`endif

FILE: src/fdrt_pkg.sv
// Types and constants of the frame dirty region tracker.
package fdrt_pkg;

	typedef struct packed {
		logic [3:0]  operation;
		logic [19:0] offset;
		logic        bank;
	} req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic        note_bank;
		logic [19:0] note_offset;
		logic        last;
		logic        empty_res;
	} rsp_t;

	// Request operations
	localparam logic [3:0] OP_TILE       = 4'd0;
	localparam logic [3:0] OP_PALETTE    = 4'd1;
	localparam logic [3:0] OP_TEXTURE    = 4'd2;
	localparam logic [3:0] OP_XLAT       = 4'd3;
	localparam logic [3:0] OP_LUMA       = 4'd4;
	localparam logic [3:0] OP_CG         = 4'd5;
	localparam logic [3:0] OP_CG_MIRROR  = 4'd6;
	localparam logic [3:0] OP_INVALIDATE = 4'd7;
	localparam logic [3:0] OP_CAPTURE    = 4'd8;
	localparam logic [3:0] OP_APPLY      = 4'd9;
	localparam logic [3:0] OP_FETCH      = 4'd10;

	// Notification kinds
	localparam logic [2:0] KIND_TILEMAP   = 3'd0;
	localparam logic [2:0] KIND_CG        = 3'd1;
	localparam logic [2:0] KIND_CG_MIRROR = 3'd2;
	localparam logic [2:0] KIND_XLAT      = 3'd3;
	localparam logic [2:0] KIND_LUMA      = 3'd4;
	localparam logic [2:0] KIND_PALETTE   = 3'd5;
	localparam logic [2:0] KIND_TEXTURE   = 3'd6;

	// Pending flag bits
	localparam int F_TILE = 0;
	localparam int F_CG   = 1;
	localparam int F_CGM  = 2;
	localparam int F_XLAT = 3;
	localparam int F_LUMA = 4;

	localparam logic [19:0] TILE_RAM_NOTE = 20'h1fffe;
	localparam int          SUMMARY_ROWS  = 3;

endpackage

FILE: src/frame_dirty_region_tracker.sv
// Top level of the frame dirty region tracker.
// Usage:
// - Request channel (req_valid/req_stall/req) carries one operation: record a
//   tile, palette, texture or flag write, invalidate, capture, apply or fetch.
// - Response channel (rsp_valid/rsp_stall/rsp) carries one notification for
//   each fetch and nothing for any other operation.
// - Tile marks live in one memory holding three 64-bit-row bitmaps (pending
//   and two slots). Capture swaps bitmap roles, then zeroes the recycled
//   bitmap one row a cycle, so it holds requests until that bitmap is clear;
//   apply and flag writes leave the request channel open, and tile writes
//   read the row, then write it back.
// - A fetch scans from the cursor for the current and the following mark, each
//   row by a memory read, then a 64-bit search. Its response is registered,
//   and requests are accepted again once it is.
// - A finished response waits in an output register; while the receiver
//   stalls, a further fetch holds until the register frees up.
// - Reset zeroes all three bitmaps in one pass with requests stalled, sets
//   the invalid flag, and leaves the report at its end, so a fetch before
//   any apply answers empty.
module frame_dirty_region_tracker #(
	parameter int TILE_MAP_BYTES      = 32768,
	parameter int PALETTE_BLOCK_SHIFT = 9,
	parameter int TEXTURE_BAND_SHIFT  = 14
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  fdrt_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output fdrt_pkg::rsp_t  rsp
);

	localparam int TW    = TILE_MAP_BYTES / 2;
	localparam int TROWS = (TW + 63) / 64;
	localparam int RW    = $clog2(TROWS + fdrt_pkg::SUMMARY_ROWS + 1);
	localparam int MRW   = (TROWS > 1) ? $clog2(TROWS) : 1;
	localparam int AW    = $clog2(3 * TROWS);
	localparam int MDEP  = 3 * TROWS;
	localparam logic [RW-1:0] ROW_END = RW'(TROWS + fdrt_pkg::SUMMARY_ROWS);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_TWR  = 6'b000010,
		ST_RD   = 6'b000100,
		ST_CHK  = 6'b001000,
		ST_PUT  = 6'b010000,
		ST_CLR  = 6'b100000
	} state_t;

	state_t state_q;

	// Bitmap memory and its clearing pass
	logic [63:0]      mem [MDEP];
	logic [63:0]      rd_q;
	logic             rd_en, wr_en;
	logic [AW-1:0]    rd_addr, wr_addr;
	logic [63:0]      wr_data;
	logic [AW-1:0]    clr_addr_q, clr_stop_q;

	// Pending marks
	logic [4:0]  pend_flags_q;
	logic [31:0] pend_pal_q;
	logic [63:0] pend_tex_q [2];
	logic        invalid_q;

	// Slot summaries and roles
	logic [4:0]  slot_flags_q [2];
	logic        slot_all_q [2];
	logic [31:0] slot_pal_q [2];
	logic [63:0] slot_tex0_q [2];
	logic [63:0] slot_tex1_q [2];
	logic        ws_q, rs_q, rep_q;
	logic [1:0]  map_pend_q;
	logic [1:0]  map_slot_q [2];

	// Tile write and scan registers
	logic [MRW-1:0] twr_row_q;
	logic [5:0]     twr_bit_q;
	logic [RW-1:0]  cur_row_q, scan_row_q, hit_row_q;
	logic [5:0]     cur_bit_q, scan_bit_q, hit_bit_q;
	logic           phase_q, empty_q, last_q;

	logic           rsp_valid_q;
	fdrt_pkg::rsp_t rsp_q;

	function automatic logic [AW-1:0] row_addr(input logic [1:0] b, input logic [MRW-1:0] r);
		row_addr = AW'(AW'(b) * AW'(TROWS) + AW'(r));
	endfunction

	function automatic logic [5:0] first_set(input logic [63:0] v);
		logic [5:0] idx;
		idx = 6'd0;
		for (int i = 63; i >= 0; i--) begin
			if (v[i]) idx = 6'(i);
		end
		first_set = idx;
	endfunction

	logic           accept;
	logic [18:0]    tw_word;
	logic [1:0]     rbuf;
	logic [191:0]   vsum;
	logic [63:0]    vrow, row_bits, masked;
	logic [RW-1:0]  srow_c;
	logic           end_row, tile_row, hit;
	logic [5:0]     hit_idx;
	logic           put_ok;

	fdrt_pkg::rsp_t rsp_c;
	logic [RW+6:0]  tpos2;
	logic [RW-1:0]  hrow_c;
	logic [7:0]     r_c;
	logic [7:0]     pr_c, tr_c;
	logic [31:0]    poff_c, toff_c;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign tw_word   = req.offset[19:1];
	assign rbuf      = map_slot_q[rep_q];
	assign put_ok    = !rsp_valid_q || !rsp_stall;

	// Build the summary positions of the reported slot
	always_comb begin
		logic all_c;
		all_c = slot_all_q[rep_q];
		vsum = '0;
		vsum[0]        = all_c | slot_flags_q[rep_q][fdrt_pkg::F_TILE];
		vsum[1]        = all_c | slot_flags_q[rep_q][fdrt_pkg::F_CG];
		vsum[2]        = slot_flags_q[rep_q][fdrt_pkg::F_CGM];
		vsum[3]        = all_c | slot_flags_q[rep_q][fdrt_pkg::F_XLAT];
		vsum[4]        = all_c | slot_flags_q[rep_q][fdrt_pkg::F_LUMA];
		vsum[36:5]     = slot_pal_q[rep_q] | {32{all_c}};
		vsum[100:37]   = slot_tex0_q[rep_q] | {64{all_c}};
		vsum[164:101]  = slot_tex1_q[rep_q] | {64{all_c}};
	end

	// Search the current scan row
	always_comb begin
		srow_c = RW'(scan_row_q - RW'(TROWS));
		case (srow_c[1:0])
			2'd0:    vrow = vsum[63:0];
			2'd1:    vrow = vsum[127:64];
			2'd2:    vrow = vsum[191:128];
			default: vrow = '0;
		endcase
		end_row  = (scan_row_q >= ROW_END);
		tile_row = (scan_row_q < RW'(TROWS));
		row_bits = tile_row ? rd_q : vrow;
		masked   = row_bits & ({64{1'b1}} << scan_bit_q);
		hit      = !end_row && (masked != 64'd0);
		hit_idx  = first_set(masked);
	end

	// Memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = row_addr(map_pend_q, twr_row_q);
		wr_data = rd_q | (64'd1 << twr_bit_q);
		if (state_q == ST_IDLE && accept && req.operation == fdrt_pkg::OP_TILE) begin
			rd_en   = 1'b1;
			rd_addr = row_addr(map_pend_q, MRW'(tw_word >> 6));
		end else if (state_q == ST_RD && scan_row_q < RW'(TROWS)) begin
			rd_en   = 1'b1;
			rd_addr = row_addr(rbuf, scan_row_q[MRW-1:0]);
		end
		if (state_q == ST_TWR) wr_en = 1'b1;
		if (state_q == ST_CLR) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end
	end

	// Bitmap memory
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	// Operation sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			clr_addr_q   <= '0;
			clr_stop_q   <= AW'(MDEP - 1);
			pend_flags_q <= '0;
			pend_pal_q   <= '0;
			pend_tex_q[0] <= '0;
			pend_tex_q[1] <= '0;
			invalid_q    <= 1'b1;
			for (int s = 0; s < 2; s++) begin
				slot_flags_q[s] <= '0;
				slot_all_q[s]   <= 1'b0;
				slot_pal_q[s]   <= '0;
				slot_tex0_q[s]  <= '0;
				slot_tex1_q[s]  <= '0;
			end
			ws_q          <= 1'b0;
			rs_q          <= 1'b0;
			rep_q         <= 1'b0;
			map_pend_q    <= 2'd0;
			map_slot_q[0] <= 2'd1;
			map_slot_q[1] <= 2'd2;
			twr_row_q     <= '0;
			twr_bit_q     <= '0;
			cur_row_q     <= ROW_END;
			cur_bit_q     <= '0;
			scan_row_q    <= '0;
			scan_bit_q    <= '0;
			hit_row_q     <= '0;
			hit_bit_q     <= '0;
			phase_q       <= 1'b0;
			empty_q       <= 1'b0;
			last_q        <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.operation)
							fdrt_pkg::OP_TILE: begin
								pend_flags_q[fdrt_pkg::F_TILE] <= 1'b1;
								twr_row_q <= MRW'(tw_word >> 6);
								twr_bit_q <= tw_word[5:0];
								if (20'(req.offset) < 20'(TILE_MAP_BYTES)) state_q <= ST_TWR;
							end
							fdrt_pkg::OP_PALETTE: begin
								pend_pal_q <= pend_pal_q | (32'd1 <<
									5'(req.offset[13:0] >> PALETTE_BLOCK_SHIFT));
							end
							fdrt_pkg::OP_TEXTURE: begin
								pend_tex_q[req.bank] <= pend_tex_q[req.bank] | (64'd1 <<
									6'(req.offset >> TEXTURE_BAND_SHIFT));
							end
							fdrt_pkg::OP_XLAT:       pend_flags_q[fdrt_pkg::F_XLAT] <= 1'b1;
							fdrt_pkg::OP_LUMA:       pend_flags_q[fdrt_pkg::F_LUMA] <= 1'b1;
							fdrt_pkg::OP_CG:         pend_flags_q[fdrt_pkg::F_CG] <= 1'b1;
							fdrt_pkg::OP_CG_MIRROR:  pend_flags_q[fdrt_pkg::F_CGM] <= 1'b1;
							fdrt_pkg::OP_INVALIDATE: invalid_q <= 1'b1;
							fdrt_pkg::OP_CAPTURE: begin
								// Hand the pending bitmap to the slot, recycle and zero the old one
								slot_flags_q[ws_q] <= pend_flags_q;
								slot_all_q[ws_q]   <= invalid_q;
								slot_pal_q[ws_q]   <= pend_pal_q;
								slot_tex0_q[ws_q]  <= pend_tex_q[0];
								slot_tex1_q[ws_q]  <= pend_tex_q[1];
								map_slot_q[ws_q]   <= map_pend_q;
								map_pend_q         <= map_slot_q[ws_q];
								clr_addr_q    <= row_addr(map_slot_q[ws_q], '0);
								clr_stop_q    <= row_addr(map_slot_q[ws_q], MRW'(TROWS - 1));
								pend_flags_q  <= '0;
								pend_pal_q    <= '0;
								pend_tex_q[0] <= '0;
								pend_tex_q[1] <= '0;
								invalid_q     <= 1'b0;
								ws_q          <= ~ws_q;
								state_q       <= ST_CLR;
							end
							fdrt_pkg::OP_APPLY: begin
								rep_q     <= rs_q;
								rs_q      <= ~rs_q;
								cur_row_q <= '0;
								cur_bit_q <= '0;
							end
							fdrt_pkg::OP_FETCH: begin
								scan_row_q <= cur_row_q;
								scan_bit_q <= cur_bit_q;
								phase_q    <= 1'b0;
								empty_q    <= 1'b0;
								state_q    <= ST_RD;
							end
							default: ;
						endcase
					end
				end
				ST_TWR: begin
					// Write back the modified pending row
					state_q <= ST_IDLE;
				end
				ST_CLR: begin
					// Zero one bitmap row per cycle
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == clr_stop_q) state_q <= ST_IDLE;
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (hit) begin
						if (!phase_q) begin
							// Record the mark, advance past it, look for a follower
							hit_row_q <= scan_row_q;
							hit_bit_q <= hit_idx;
							phase_q   <= 1'b1;
							if (hit_idx == 6'd63) begin
								cur_row_q  <= scan_row_q + RW'(1);
								cur_bit_q  <= '0;
								scan_row_q <= scan_row_q + RW'(1);
								scan_bit_q <= '0;
							end else begin
								cur_row_q  <= scan_row_q;
								cur_bit_q  <= hit_idx + 6'd1;
								scan_row_q <= scan_row_q;
								scan_bit_q <= hit_idx + 6'd1;
							end
							state_q <= ST_RD;
						end else begin
							last_q  <= 1'b0;
							state_q <= ST_PUT;
						end
					end else if (end_row) begin
						if (!phase_q) begin
							empty_q   <= 1'b1;
							cur_row_q <= ROW_END;
							cur_bit_q <= '0;
						end
						last_q  <= 1'b1;
						state_q <= ST_PUT;
					end else begin
						scan_row_q <= scan_row_q + RW'(1);
						scan_bit_q <= '0;
						state_q    <= ST_RD;
					end
				end
				ST_PUT: begin
					if (put_ok) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Format the notification from the hit position
	always_comb begin
		tpos2  = {hit_row_q, hit_bit_q, 1'b0};
		hrow_c = RW'(hit_row_q - RW'(TROWS));
		r_c    = {hrow_c[1:0], hit_bit_q};
		pr_c   = r_c - 8'd5;
		tr_c   = r_c - 8'd37;
		poff_c = 32'(pr_c[4:0]) << PALETTE_BLOCK_SHIFT;
		toff_c = 32'(tr_c[5:0]) << TEXTURE_BAND_SHIFT;
		rsp_c  = '0;
		if (empty_q) begin
			rsp_c.empty_res = 1'b1;
		end else begin
			rsp_c.last = last_q;
			if (hit_row_q < RW'(TROWS)) begin
				rsp_c.kind        = fdrt_pkg::KIND_TILEMAP;
				rsp_c.note_offset = 20'(tpos2);
			end else if (r_c == 8'd0) begin
				rsp_c.kind        = fdrt_pkg::KIND_TILEMAP;
				rsp_c.note_offset = fdrt_pkg::TILE_RAM_NOTE;
			end else if (r_c == 8'd1) begin
				rsp_c.kind = fdrt_pkg::KIND_CG;
			end else if (r_c == 8'd2) begin
				rsp_c.kind = fdrt_pkg::KIND_CG_MIRROR;
			end else if (r_c == 8'd3) begin
				rsp_c.kind = fdrt_pkg::KIND_XLAT;
			end else if (r_c == 8'd4) begin
				rsp_c.kind = fdrt_pkg::KIND_LUMA;
			end else if (r_c < 8'd37) begin
				rsp_c.kind        = fdrt_pkg::KIND_PALETTE;
				rsp_c.note_offset = poff_c[19:0];
			end else begin
				rsp_c.kind        = fdrt_pkg::KIND_TEXTURE;
				rsp_c.note_bank   = tr_c[6];
				rsp_c.note_offset = toff_c[19:0];
			end
		end
	end

	// Load the response register, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (state_q == ST_PUT && put_ok) begin
			rsp_valid_q <= 1'b1;
			rsp_q       <= rsp_c;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: src/fdrt_checker.sv
// Port checker of the frame dirty region tracker and its bind.
`include "frame_dirty_region_tracker_assert.svh"
module fdrt_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input fdrt_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input fdrt_pkg::rsp_t rsp
);

	logic flag_kind;
	assign flag_kind = (rsp.kind == fdrt_pkg::KIND_CG) || (rsp.kind == fdrt_pkg::KIND_CG_MIRROR) ||
		(rsp.kind == fdrt_pkg::KIND_XLAT) || (rsp.kind == fdrt_pkg::KIND_LUMA);

	// Hold a stalled response
	`FDRT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	// Empty responses carry nothing else
	`FDRT_ASSERT_NOW(a_empty_clean, rsp_valid && rsp.empty_res, (rsp.kind == fdrt_pkg::KIND_TILEMAP) && (rsp.note_offset == 20'd0) && !rsp.note_bank && !rsp.last)
	// Only texture notes carry a bank
	`FDRT_ASSERT_NOW(a_bank_texture, rsp_valid && (rsp.kind != fdrt_pkg::KIND_TEXTURE), !rsp.note_bank)
	// Flag notes carry no offset
	`FDRT_ASSERT_NOW(a_flag_offset, rsp_valid && flag_kind, rsp.note_offset == 20'd0)

endmodule

bind frame_dirty_region_tracker fdrt_checker u_fdrt_checker (.*);
